// File: rtl/gqm_pkg.sv
// Shared constants of the greedy quad mesher: plane size and derived widths.
`default_nettype none

package gqm_pkg;

	// Rows in the plane, and bits in each row.
	localparam int PLANE_SIZE = 16;
	// Bits that address one row or one column.
	localparam int IDX_W = $clog2(PLANE_SIZE);
	// Bits that hold a count or a cursor from zero up to PLANE_SIZE itself.
	localparam int CNT_W = $clog2(PLANE_SIZE + 1);

endpackage

`default_nettype wire

// File: rtl/gqm_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module gqm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/greedy_quad_mesher_bitplane.sv
// Top level of the greedy quad mesher over one bit plane held in a RAM.
// A load word gives no result and leaves the engine idle. A take word's result is registered
// once the engine has gone from IDLE through SCAN over the rows scanned and GROW over the
// rows checked below the quad to EMIT, or from IDLE straight to EMIT when the plane is
// already exhausted; the walk over the rows through the single RAM read port sets it. A new
// word is taken only while the engine is idle; one result waits in the output register.
// Reset clears the cursor and the per-row valid bits at once, so the plane reads as all zeros.
`default_nettype none

module greedy_quad_mesher_bitplane (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        func,
	input  wire logic [3:0]  row_index,
	input  wire logic [15:0] row_bits,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             found,
	output logic [3:0]       quad_x,
	output logic [3:0]       quad_y,
	output logic [4:0]       quad_width,
	output logic [4:0]       quad_height
);

	import gqm_pkg::*;

	// IDLE waits for a word. SCAN looks at the row that the RAM has just returned for a set
	// bit at or right of the cursor. GROW checks whether the next row covers the span of
	// the quad. EMIT hands the finished result to the output register.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_GROW,
		ST_EMIT
	} state_t;

	state_t state_q;

	// Scan cursor; both may reach PLANE_SIZE, which marks the end of a row or of the plane.
	logic [CNT_W-1:0] scan_row_q;
	logic [CNT_W-1:0] scan_col_q;
	// Row being checked while the quad grows downward.
	logic [CNT_W-1:0] grow_row_q;

	// Quad under construction.
	logic                  found_q;
	logic [IDX_W-1:0]      x_q;
	logic [IDX_W-1:0]      y_q;
	logic [CNT_W-1:0]      w_q;
	logic [CNT_W-1:0]      h_q;
	logic [PLANE_SIZE-1:0] span_q;

	// A row that was never written reads as zero: one valid bit per row, cleared by reset.
	logic [PLANE_SIZE-1:0] row_valid_q;
	logic                  rd_valid_s1;

	// Output register.
	logic             out_valid_q;
	logic             found_out_q;
	logic [3:0]       quad_x_q;
	logic [3:0]       quad_y_q;
	logic [4:0]       quad_width_q;
	logic [4:0]       quad_height_q;

	// RAM port signals.
	logic                  ram_we;
	logic [IDX_W-1:0]      ram_waddr;
	logic [PLANE_SIZE-1:0] ram_wdata;
	logic                  ram_re;
	logic [IDX_W-1:0]      ram_raddr;
	logic [PLANE_SIZE-1:0] ram_rdata;

	gqm_ram #(
		.WIDTH(PLANE_SIZE),
		.DEPTH(PLANE_SIZE)
	) u_plane (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	logic                  accept;
	logic                  load_in_range;
	logic [PLANE_SIZE-1:0] rd_row;
	logic [PLANE_SIZE-1:0] col_mask;
	logic [PLANE_SIZE-1:0] masked;
	logic [PLANE_SIZE-1:0] lsb;
	logic [PLANE_SIZE:0]   run_sum;
	logic [PLANE_SIZE:0]   run_end;
	logic [PLANE_SIZE-1:0] span;
	logic [IDX_W-1:0]      hit_x;
	logic [CNT_W-1:0]      hit_end;
	logic [CNT_W-1:0]      scan_row_next;
	logic [CNT_W-1:0]      grow_row_next;
	logic                  scan_last;
	logic                  grow_last;
	logic                  grow_fits;
	logic                  out_free;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign load_in_range = (int'(row_index) < PLANE_SIZE);

	assign rd_row = rd_valid_s1 ? ram_rdata : '0;

	// Bits at or right of the cursor column; a cursor at PLANE_SIZE leaves none.
	assign col_mask = PLANE_SIZE'({(PLANE_SIZE + 1){1'b1}} << scan_col_q);
	assign masked   = rd_row & col_mask;
	// Lowest candidate bit, isolated.
	assign lsb      = masked & (~masked + PLANE_SIZE'(1));
	// Adding the isolated bit ripples through the run of ones and lands just past its end.
	assign run_sum  = {1'b0, rd_row} + {1'b0, lsb};
	assign run_end  = run_sum & ~{1'b0, rd_row};
	assign span     = rd_row & ~run_sum[PLANE_SIZE-1:0];

	// Both vectors are one-hot (or zero), so the encoders simply OR the matching indices.
	always_comb begin
		hit_x = '0;
		for (int i = 0; i < PLANE_SIZE; i++) begin
			if (lsb[i]) begin
				hit_x = hit_x | IDX_W'(i);
			end
		end
	end

	always_comb begin
		hit_end = '0;
		for (int i = 0; i <= PLANE_SIZE; i++) begin
			if (run_end[i]) begin
				hit_end = hit_end | CNT_W'(i);
			end
		end
	end

	assign scan_row_next = scan_row_q + CNT_W'(1);
	assign grow_row_next = grow_row_q + CNT_W'(1);
	assign scan_last     = (scan_row_next == CNT_W'(PLANE_SIZE));
	assign grow_last     = (grow_row_next == CNT_W'(PLANE_SIZE));
	assign grow_fits     = ((rd_row & span_q) == span_q);

	// RAM access: a read issued in one cycle delivers its row to the next state. Each
	// write-back goes to the row just examined while the read moves on to the row below,
	// so a read never meets a write to the same entry in flight.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept && !func && load_in_range) begin
					ram_we    = 1'b1;
					ram_waddr = IDX_W'(row_index);
					ram_wdata = PLANE_SIZE'(row_bits);
				end
				if (accept && func && (scan_row_q != CNT_W'(PLANE_SIZE))) begin
					ram_re    = 1'b1;
					ram_raddr = scan_row_q[IDX_W-1:0];
				end
			end
			ST_SCAN: begin
				if (masked != '0) begin
					ram_we    = 1'b1;
					ram_waddr = scan_row_q[IDX_W-1:0];
					ram_wdata = rd_row & ~span;
				end
				if (!scan_last) begin
					ram_re    = 1'b1;
					ram_raddr = scan_row_next[IDX_W-1:0];
				end
			end
			ST_GROW: begin
				if (grow_fits) begin
					ram_we    = 1'b1;
					ram_waddr = grow_row_q[IDX_W-1:0];
					ram_wdata = rd_row & ~span_q;
					if (!grow_last) begin
						ram_re    = 1'b1;
						ram_raddr = grow_row_next[IDX_W-1:0];
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			scan_row_q    <= '0;
			scan_col_q    <= '0;
			grow_row_q    <= '0;
			found_q       <= 1'b0;
			x_q           <= '0;
			y_q           <= '0;
			w_q           <= '0;
			h_q           <= '0;
			span_q        <= '0;
			row_valid_q   <= '0;
			rd_valid_s1   <= 1'b0;
			out_valid_q   <= 1'b0;
			found_out_q   <= 1'b0;
			quad_x_q      <= '0;
			quad_y_q      <= '0;
			quad_width_q  <= '0;
			quad_height_q <= '0;
		end else begin
			if (ram_we) begin
				row_valid_q[ram_waddr] <= 1'b1;
			end
			if (ram_re) begin
				rd_valid_s1 <= row_valid_q[ram_raddr];
			end
			// In EMIT the output register is refilled instead, whenever it drains.
			if (out_valid_q && !out_stall && (state_q != ST_EMIT)) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (!func) begin
							// A load rewinds the cursor even when its row is out of range.
							scan_row_q <= '0;
							scan_col_q <= '0;
						end else if (scan_row_q == CNT_W'(PLANE_SIZE)) begin
							// Plane already exhausted: answer with an empty result.
							found_q <= 1'b0;
							x_q     <= '0;
							y_q     <= '0;
							w_q     <= '0;
							h_q     <= '0;
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (masked == '0) begin
						// Nothing left in this row: move to the start of the next one.
						scan_row_q <= scan_row_next;
						scan_col_q <= '0;
						if (scan_last) begin
							found_q <= 1'b0;
							x_q     <= '0;
							y_q     <= '0;
							w_q     <= '0;
							h_q     <= '0;
							state_q <= ST_EMIT;
						end
					end else begin
						found_q    <= 1'b1;
						x_q        <= hit_x;
						y_q        <= scan_row_q[IDX_W-1:0];
						w_q        <= hit_end - CNT_W'(hit_x);
						h_q        <= CNT_W'(1);
						span_q     <= span;
						scan_col_q <= hit_end;
						grow_row_q <= scan_row_next;
						state_q    <= scan_last ? ST_EMIT : ST_GROW;
					end
				end
				ST_GROW: begin
					if (grow_fits) begin
						h_q        <= h_q + CNT_W'(1);
						grow_row_q <= grow_row_next;
						if (grow_last) begin
							state_q <= ST_EMIT;
						end
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					// Hold the result until the output register is empty or being drained.
					if (out_free) begin
						out_valid_q   <= 1'b1;
						found_out_q   <= found_q;
						quad_x_q      <= 4'(x_q);
						quad_y_q      <= 4'(y_q);
						quad_width_q  <= 5'(w_q);
						quad_height_q <= 5'(h_q);
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign found       = found_out_q;
	assign quad_x      = quad_x_q;
	assign quad_y      = quad_y_q;
	assign quad_width  = quad_width_q;
	assign quad_height = quad_height_q;

endmodule

`default_nettype wire

// File: tb/sv/gqm_tb_pkg.sv
`timescale 1ns / 1ps
// Word codes and the quad record shared by the mesher testbench files.
package gqm_tb_pkg;

	// Operation carried by the func field of an input word.
	typedef enum logic {
		FUNC_LOAD = 1'b0,
		FUNC_TAKE = 1'b1
	} func_t;

	// One result word as the block presents it.
	typedef struct packed {
		logic       found;
		logic [3:0] x;
		logic [3:0] y;
		logic [4:0] width;
		logic [4:0] height;
	} quad_t;

endpackage

// File: tb/sv/gqm_checker.sv
`timescale 1ns / 1ps
// Checker for the greedy quad mesher: mirrors the plane, predicts quads, compares results.
module gqm_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic        func,
	input  wire logic [3:0]  row_index,
	input  wire logic [15:0] row_bits,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic        found,
	input  wire logic [3:0]  quad_x,
	input  wire logic [3:0]  quad_y,
	input  wire logic [4:0]  quad_width,
	input  wire logic [4:0]  quad_height,
	output int               fail_count,
	output int               pending
);
	import gqm_pkg::*;
	import gqm_tb_pkg::*;

	localparam int REPORT_LIMIT = 10;

	logic [PLANE_SIZE-1:0] plane [PLANE_SIZE];
	int cursor_row = 0;
	int cursor_col = 0;
	int mismatches = 0;
	int outstanding = 0;
	quad_t awaited_quads [$];

	assign fail_count = mismatches;
	assign pending = outstanding;

	// Resumes the row-major scan, grows the quad right then down, and clears what it covers.
	task automatic carve_quad(output quad_t q);
		int c;
		int r;
		int x0;
		int y0;
		bit hit;
		logic [PLANE_SIZE-1:0] bits;
		logic [PLANE_SIZE-1:0] span;
		q = '0;
		hit = 1'b0;
		while (cursor_row < PLANE_SIZE && !hit) begin
			bits = plane[cursor_row];
			for (c = cursor_col; c < PLANE_SIZE; c++) begin
				if (bits[c]) begin
					hit = 1'b1;
					break;
				end
			end
			if (hit) begin
				x0 = c;
				y0 = cursor_row;
				span = '0;
				while (c < PLANE_SIZE && bits[c]) begin
					span[c] = 1'b1;
					c++;
				end
				plane[y0] &= ~span;
				q.height = 5'd1;
				for (r = y0 + 1; r < PLANE_SIZE; r++) begin
					if ((plane[r] & span) != span)
						break;
					plane[r] &= ~span;
					q.height++;
				end
				q.found = 1'b1;
				q.x = 4'(x0);
				q.y = 4'(y0);
				q.width = 5'(c - x0);
				cursor_col = c;
			end else begin
				cursor_row++;
				cursor_col = 0;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		quad_t want;
		quad_t got;
		quad_t fresh;
		if (!arst_n) begin
			for (int r = 0; r < PLANE_SIZE; r++)
				plane[r] = '0;
			cursor_row = 0;
			cursor_col = 0;
			awaited_quads.delete();
			outstanding = 0;
		end else begin
			// Results first, so a take accepted at this same edge cannot match them.
			if (out_valid && !out_stall) begin
				got = {found, quad_x, quad_y, quad_width, quad_height};
				if (awaited_quads.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("gqm_checker: unexpected result found=%0d x=%0d y=%0d w=%0d h=%0d",
							got.found, got.x, got.y, got.width, got.height);
				end else begin
					want = awaited_quads.pop_front();
					if (got.found !== want.found || got.x !== want.x || got.y !== want.y ||
						got.width !== want.width || got.height !== want.height) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT)
							$display({"gqm_checker: mismatch expected found=%0d x=%0d y=%0d w=%0d h=%0d,",
								" got found=%0d x=%0d y=%0d w=%0d h=%0d"},
								want.found, want.x, want.y, want.width, want.height,
								got.found, got.x, got.y, got.width, got.height);
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (func == FUNC_LOAD) begin
					plane[row_index] = row_bits;
					cursor_row = 0;
					cursor_col = 0;
				end else begin
					carve_quad(fresh);
					awaited_quads = {awaited_quads, fresh};
				end
			end
			outstanding = awaited_quads.size();
		end
	end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the greedy quad mesher: stimulus, idling, back-pressure and the verdict.
module tb_top;
	import gqm_pkg::*;
	import gqm_tb_pkg::*;

	// Random words after the directed part, split evenly over four idling phases.
	localparam int RUN_WORDS = 1550;
	// The long receiver hold-off, long enough for the block to fill and stall its input.
	localparam int HOLD_CYCLES = 600;
	// This covers the walk over the rows of any take still in flight.
	localparam int DRAIN_CYCLES = 2 * PLANE_SIZE + 16;
	// Far above the slowest legal run: every word waiting out the longest gaps and stalls.
	localparam int unsigned CYCLE_LIMIT = 1_000_000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        func = FUNC_LOAD;
	logic [3:0]  row_index = '0;
	logic [15:0] row_bits = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        found;
	logic [3:0]  quad_x;
	logic [3:0]  quad_y;
	logic [4:0]  quad_width;
	logic [4:0]  quad_height;

	int fail_count;
	int pending;

	// Percent chance per cycle that the sender idles or the receiver stalls.
	int idle_pct = 0;
	int stall_pct = 0;
	int words_sent = 0;
	int unsigned cycle_count = 0;
	logic hold_req = 1'b0;
	logic hold_on = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	greedy_quad_mesher_bitplane dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.func        (func),
		.row_index   (row_index),
		.row_bits    (row_bits),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.found       (found),
		.quad_x      (quad_x),
		.quad_y      (quad_y),
		.quad_width  (quad_width),
		.quad_height (quad_height)
	);

	gqm_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.func        (func),
		.row_index   (row_index),
		.row_bits    (row_bits),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.found       (found),
		.quad_x      (quad_x),
		.quad_y      (quad_y),
		.quad_width  (quad_width),
		.quad_height (quad_height),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	// The receiver stalls at random, and always while the long hold-off is on.
	always @(posedge clk)
		out_stall <= hold_on || ($urandom_range(99) < stall_pct);

	// The hold-off counts its own cycles once the stimulus asks for it, while the sender
	// keeps offering words; the one pending result then blocks the engine and its input.
	initial begin
		wait (hold_req);
		hold_on <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_on <= 1'b0;
	end

	// A hung handshake must not run forever.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	// Offers one word, idling first at random. Valid is lowered only to idle, so it is never
	// lowered and raised at the same edge. The stall is read at the falling edge, where it has
	// settled, and decides whether the next rising edge takes the word.
	task automatic send_word(input func_t f, input logic [3:0] idx, input logic [15:0] bits);
		bit taken;
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		row_index <= idx;
		row_bits <= bits;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
		words_sent++;
	endtask

	// Row patterns: noise, sparse, dense, full, empty, and single runs of set bits.
	function automatic logic [15:0] pick_row();
		int lo;
		int len;
		logic [15:0] v;
		case ($urandom_range(6))
			0: v = 16'($urandom);
			1: v = 16'($urandom & $urandom & $urandom);
			2: v = 16'($urandom | $urandom);
			3: v = 16'hFFFF;
			4: v = 16'h0000;
			default: begin
				lo = $urandom_range(15);
				len = $urandom_range(16 - lo, 1);
				v = 16'(((17'h1 << len) - 17'h1) << lo);
			end
		endcase
		return v;
	endfunction

	// One meshing pass: fill some or all rows, then pull quads. Rows are often repeated so
	// quads grow downward. A few stray loads land among the takes and rewind the scan.
	task automatic mesh_session();
		logic [15:0] prev;
		int n_loads;
		int n_takes;
		bit whole_plane;
		prev = pick_row();
		whole_plane = 1'($urandom_range(1));
		n_loads = whole_plane ? PLANE_SIZE : $urandom_range(6, 1);
		for (int i = 0; i < n_loads; i++) begin
			if ($urandom_range(99) >= 40)
				prev = pick_row();
			send_word(FUNC_LOAD, whole_plane ? 4'(i) : 4'($urandom), prev);
		end
		n_takes = ($urandom_range(99) < 25) ? $urandom_range(80, 30) : $urandom_range(20, 1);
		for (int i = 0; i < n_takes; i++) begin
			if ($urandom_range(99) < 6)
				send_word(FUNC_LOAD, 4'($urandom), pick_row());
			else
				send_word(FUNC_TAKE, 4'($urandom), 16'($urandom));
		end
	endtask

	initial begin
		int target;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part. A take on the empty plane after reset must report nothing found.
		send_word(FUNC_TAKE, 4'h0, 16'h0000);
		// A full plane comes back as one quad covering all sixteen rows and columns,
		// and the take after it finds the plane exhausted.
		for (int i = 0; i < PLANE_SIZE; i++)
			send_word(FUNC_LOAD, 4'(i), 16'hFFFF);
		send_word(FUNC_TAKE, 4'h0, 16'h0000);
		send_word(FUNC_TAKE, 4'hF, 16'hFFFF);
		// The bottom right corner alone, then a second take with the cursor parked at the end.
		send_word(FUNC_LOAD, 4'hF, 16'h8000);
		send_word(FUNC_TAKE, 4'h0, 16'h0000);
		send_word(FUNC_TAKE, 4'h0, 16'h0000);
		// The top left corner, and an empty row load that still rewinds the scan.
		send_word(FUNC_LOAD, 4'h0, 16'h0001);
		send_word(FUNC_LOAD, 4'h7, 16'h0000);
		send_word(FUNC_TAKE, 4'h0, 16'h0000);

		// Random part in four idling phases: hold-off only, sender idle, receiver stalling, both.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					idle_pct = 0;
					stall_pct <= 0;
					hold_req <= 1'b1;
				end
				1: begin
					idle_pct = 82;
					stall_pct <= 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct <= 82;
				end
				default: begin
					idle_pct = 33;
					stall_pct <= 33;
				end
			endcase
			target = words_sent + RUN_WORDS / 4;
			while (words_sent < target)
				mesh_session();
		end
		in_valid <= 1'b0;

		// Let every expected quad come out, then watch a while longer for stray results.
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

// File: filelist.f
rtl/gqm_pkg.sv
rtl/gqm_ram.sv
rtl/greedy_quad_mesher_bitplane.sv
tb/sv/gqm_tb_pkg.sv
tb/sv/gqm_checker.sv
tb/sv/tb_top.sv
